// File: rtl/ookr_pkg.sv
// Shared types, timing windows and helpers for the OOK pulse width receiver.
package ookr_pkg;

   localparam int TIME_WIDTH = 24;
   localparam int NUM_PROTOCOLS = 2;
   localparam int MSG_WIDTH = 32;
   localparam int COUNT_WIDTH = 6;
   localparam int TOLERANCE_PCT = 133;

   localparam int UNIT0_US = 475;
   localparam int UNIT1_US = 180;

   localparam int SYNC0_T = UNIT0_US * (9000 / UNIT0_US);
   localparam int ONE_LOW0_T = UNIT0_US * (4000 / UNIT0_US);
   localparam int ZERO_LOW0_T = UNIT0_US * (2000 / UNIT0_US);
   localparam int ONE_HIGH0_T = UNIT0_US * 1;
   localparam int ZERO_HIGH0_T = UNIT0_US * 1;

   localparam int SYNC1_T = UNIT1_US * 31;
   localparam int ONE_LOW1_T = UNIT1_US * 1;
   localparam int ZERO_LOW1_T = UNIT1_US * 3;
   localparam int ONE_HIGH1_T = UNIT1_US * 3;
   localparam int ZERO_HIGH1_T = UNIT1_US * 1;

   localparam logic [TIME_WIDTH-1:0] SYNC0_LO = TIME_WIDTH'(SYNC0_T * 100 / TOLERANCE_PCT);
   localparam logic [TIME_WIDTH-1:0] SYNC0_HI = TIME_WIDTH'(SYNC0_T * TOLERANCE_PCT / 100);
   localparam logic [TIME_WIDTH-1:0] SYNC1_LO = TIME_WIDTH'(SYNC1_T * 100 / TOLERANCE_PCT);
   localparam logic [TIME_WIDTH-1:0] SYNC1_HI = TIME_WIDTH'(SYNC1_T * TOLERANCE_PCT / 100);

   localparam logic [TIME_WIDTH-1:0] ONE_LOW0_LO =
      TIME_WIDTH'(ONE_LOW0_T * 100 / TOLERANCE_PCT);
   localparam logic [TIME_WIDTH-1:0] ONE_LOW0_HI =
      TIME_WIDTH'(ONE_LOW0_T * TOLERANCE_PCT / 100);
   localparam logic [TIME_WIDTH-1:0] ONE_LOW1_LO =
      TIME_WIDTH'(ONE_LOW1_T * 100 / TOLERANCE_PCT);
   localparam logic [TIME_WIDTH-1:0] ONE_LOW1_HI =
      TIME_WIDTH'(ONE_LOW1_T * TOLERANCE_PCT / 100);

   localparam logic [TIME_WIDTH-1:0] ZERO_LOW0_LO =
      TIME_WIDTH'(ZERO_LOW0_T * 100 / TOLERANCE_PCT);
   localparam logic [TIME_WIDTH-1:0] ZERO_LOW0_HI =
      TIME_WIDTH'(ZERO_LOW0_T * TOLERANCE_PCT / 100);
   localparam logic [TIME_WIDTH-1:0] ZERO_LOW1_LO =
      TIME_WIDTH'(ZERO_LOW1_T * 100 / TOLERANCE_PCT);
   localparam logic [TIME_WIDTH-1:0] ZERO_LOW1_HI =
      TIME_WIDTH'(ZERO_LOW1_T * TOLERANCE_PCT / 100);

   localparam logic [TIME_WIDTH-1:0] ONE_HIGH0_LO =
      TIME_WIDTH'(ONE_HIGH0_T * 100 / TOLERANCE_PCT);
   localparam logic [TIME_WIDTH-1:0] ONE_HIGH0_HI =
      TIME_WIDTH'(ONE_HIGH0_T * TOLERANCE_PCT / 100);
   localparam logic [TIME_WIDTH-1:0] ONE_HIGH1_LO =
      TIME_WIDTH'(ONE_HIGH1_T * 100 / TOLERANCE_PCT);
   localparam logic [TIME_WIDTH-1:0] ONE_HIGH1_HI =
      TIME_WIDTH'(ONE_HIGH1_T * TOLERANCE_PCT / 100);

   localparam logic [TIME_WIDTH-1:0] ZERO_HIGH0_LO =
      TIME_WIDTH'(ZERO_HIGH0_T * 100 / TOLERANCE_PCT);
   localparam logic [TIME_WIDTH-1:0] ZERO_HIGH0_HI =
      TIME_WIDTH'(ZERO_HIGH0_T * TOLERANCE_PCT / 100);
   localparam logic [TIME_WIDTH-1:0] ZERO_HIGH1_LO =
      TIME_WIDTH'(ZERO_HIGH1_T * 100 / TOLERANCE_PCT);
   localparam logic [TIME_WIDTH-1:0] ZERO_HIGH1_HI =
      TIME_WIDTH'(ZERO_HIGH1_T * TOLERANCE_PCT / 100);

   localparam logic [COUNT_WIDTH-1:0] MSG_LEN0 = COUNT_WIDTH'(32);
   localparam logic [COUNT_WIDTH-1:0] MSG_LEN1 = COUNT_WIDTH'(24);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = COUNT_WIDTH'(MSG_WIDTH);

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic                  op;
      logic                  level;
      logic [23:0]           interval_us;
   } req_type;

   typedef struct packed {
      logic                   ready_res;
      logic                   protocol;
      logic [COUNT_WIDTH-1:0] bit_length;
      logic [MSG_WIDTH-1:0]   message;
   } rsp_type;

   typedef struct packed {
      logic                     clear;
      logic                     level;
      logic [NUM_PROTOCOLS-1:0] sync_hit;
      logic [NUM_PROTOCOLS-1:0] one_low_hit;
      logic [NUM_PROTOCOLS-1:0] zero_low_hit;
      logic [NUM_PROTOCOLS-1:0] high_hit;
   } cls_type;

   function automatic logic in_window(input logic [TIME_WIDTH-1:0] val,
                                      input logic [TIME_WIDTH-1:0] lo,
                                      input logic [TIME_WIDTH-1:0] hi);
      return (val >= lo) && (val <= hi);
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] msg_len(input logic prot);
      return prot ? MSG_LEN1 : MSG_LEN0;
   endfunction

endpackage

// File: rtl/ookr_front.sv
// Front end: classify edge widths against all windows and queue the result.
module ookr_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  ookr_pkg::req_type req_data,
   output logic            cls_valid,
   output ookr_pkg::cls_type cls_data,
   input  logic            cls_take
);
   import ookr_pkg::*;

   logic [TIME_WIDTH-1:0] iv;
   cls_type               cls_in;
   cls_type               entry_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  push_ok;

   assign iv = req_data.interval_us[TIME_WIDTH-1:0];

   always_comb begin
      cls_in.clear = (req_data.op == OP_CLEAR);
      cls_in.level = req_data.level;
      cls_in.sync_hit = {in_window(iv, SYNC1_LO, SYNC1_HI), in_window(iv, SYNC0_LO, SYNC0_HI)};
      cls_in.one_low_hit = {in_window(iv, ONE_LOW1_LO, ONE_LOW1_HI),
                            in_window(iv, ONE_LOW0_LO, ONE_LOW0_HI)};
      cls_in.zero_low_hit = {in_window(iv, ZERO_LOW1_LO, ZERO_LOW1_HI),
                             in_window(iv, ZERO_LOW0_LO, ZERO_LOW0_HI)};
      cls_in.high_hit = {in_window(iv, ONE_HIGH1_LO, ONE_HIGH1_HI) ||
                         in_window(iv, ZERO_HIGH1_LO, ZERO_HIGH1_HI),
                         in_window(iv, ONE_HIGH0_LO, ONE_HIGH0_HI) ||
                         in_window(iv, ZERO_HIGH0_LO, ZERO_HIGH0_HI)};
   end

   assign full = (count_ff == 2'd2);
   assign push_ok = push && !full;
   assign cls_valid = (count_ff != 2'd0);
   assign cls_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ (cls_take && cls_valid);
      count_in = count_ff + {1'b0, push_ok} - {1'b0, cls_take && cls_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= cls_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("front queue count out of range");
   a_push_empty: assert property (@(posedge clock) disable iff (reset)
      (push_ok && count_ff == 2'd0) |=> cls_valid) else $error("queued item lost");
   a_drain_last: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1 && cls_take && !push_ok) |=> !cls_valid)
      else $error("front queue invented an item");

endmodule

// File: rtl/ookr_back.sv
// Back end: sync and bit-shift state, message hold, and the result queue.
module ookr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cls_valid,
   input  ookr_pkg::cls_type cls_data,
   output logic              cls_take,
   output logic              empty,
   input  logic              pop,
   output ookr_pkg::rsp_type rsp_data
);
   import ookr_pkg::*;

   logic                   synced_ff, synced_in;
   logic                   prot_ff, prot_in;
   logic [MSG_WIDTH-1:0]   shift_ff, shift_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   ready_ff, ready_in;
   logic [COUNT_WIDTH-1:0] len;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic                   eom;
   rsp_type                rsp_in;

   rsp_type                res_ff [2];
   logic                   wr_ptr_ff, rd_ptr_ff;
   logic [1:0]             res_count_ff, res_count_in;
   logic                   res_full;
   logic                   pop_ok;

   assign res_full = (res_count_ff == 2'd2);
   assign cls_take = cls_valid && !res_full;
   assign len = msg_len(prot_ff);
   assign count_inc = (count_ff < COUNT_MAX) ? count_ff + COUNT_WIDTH'(1) : count_ff;

   always_comb begin
      synced_in = synced_ff;
      prot_in = prot_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      ready_in = ready_ff;
      eom = 1'b0;
      if (cls_data.clear) begin
         ready_in = 1'b0;
         shift_in = '0;
         prot_in = 1'b0;
         synced_in = 1'b0;
      end else if (!ready_ff) begin
         if (cls_data.level) begin
            if (!synced_ff) begin
               if (cls_data.sync_hit[1]) begin
                  synced_in = 1'b1;
                  prot_in = 1'b1;
                  shift_in = '0;
                  count_in = '0;
               end else if (cls_data.sync_hit[0]) begin
                  synced_in = 1'b1;
                  prot_in = 1'b0;
                  shift_in = '0;
                  count_in = '0;
               end
            end else if (cls_data.one_low_hit[prot_ff]) begin
               count_in = count_inc;
               shift_in = {shift_ff[MSG_WIDTH-2:0], 1'b1};
            end else if (cls_data.zero_low_hit[prot_ff]) begin
               count_in = count_inc;
               shift_in = {shift_ff[MSG_WIDTH-2:0], 1'b0};
            end else begin
               eom = 1'b1;
            end
         end else if (synced_ff) begin
            eom = !cls_data.high_hit[prot_ff] || (count_ff >= len);
         end
         if (eom) begin
            if (count_ff >= len) begin
               ready_in = 1'b1;
            end
            synced_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      if (ready_in) begin
         rsp_in.ready_res = 1'b1;
         rsp_in.protocol = prot_in;
         rsp_in.bit_length = msg_len(prot_in);
         rsp_in.message = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff <= 1'b0;
         prot_ff <= 1'b0;
         shift_ff <= '0;
         count_ff <= '0;
         ready_ff <= 1'b0;
      end else if (cls_take) begin
         synced_ff <= synced_in;
         prot_ff <= prot_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
         ready_ff <= ready_in;
      end
   end

   assign empty = (res_count_ff == 2'd0);
   assign pop_ok = pop && !empty;
   assign rsp_data = res_ff[rd_ptr_ff];
   assign res_count_in = res_count_ff + {1'b0, cls_take} - {1'b0, pop_ok};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         res_count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ cls_take;
         rd_ptr_ff <= rd_ptr_ff ^ pop_ok;
         res_count_ff <= res_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cls_take) begin
         res_ff[wr_ptr_ff] <= rsp_in;
      end
   end

   a_sync_hold_excl: assert property (@(posedge clock) disable iff (reset)
      !(synced_ff && ready_ff)) else $error("synced while a message is held");
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX) else $error("bit count past saturation");
   a_res_bound: assert property (@(posedge clock) disable iff (reset)
      res_count_ff <= 2'd2) else $error("result queue count out of range");
   a_held_stable: assert property (@(posedge clock) disable iff (reset)
      (ready_ff && cls_take && !cls_data.clear) |=> (ready_ff && $stable(shift_ff)))
      else $error("held message changed without a clear");

endmodule

// File: rtl/ook_pulse_width_receiver.sv
// Top level of the OOK pulse width receiver.
// Usage: each input transfer on req_data is either a pin edge event (op edge,
// with the new level and the microseconds since the previous edge) or a clear
// of the held message. An input transfer happens when push is high and full is
// low. Every input transfer yields exactly one result: ready_res, protocol,
// bit_length and message as they stand after that item. Results wait in a
// two-entry queue; the head is on rsp_data while empty is low and is taken
// when pop is high.
// Path: a taken item is registered in the classification queue, and its result
// is registered in the result queue, whose head drives rsp_data.
// Throughput: one item per cycle while the result queue has room; the front
// classifier checks all windows in parallel; the back applies one per cycle.
// Stall: when pop stays low the result queue fills, the back stops taking
// from the two-entry classification queue, and full rises once that fills.
// Reset: synchronous; clears both queues and all receiver state.
module ook_pulse_width_receiver (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  ookr_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output ookr_pkg::rsp_type rsp_data
);
   import ookr_pkg::*;

   logic    cls_valid;
   logic    cls_take;
   cls_type cls_data;

   ookr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cls_valid (cls_valid),
      .cls_data  (cls_data),
      .cls_take  (cls_take)
   );

   ookr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cls_valid (cls_valid),
      .cls_data  (cls_data),
      .cls_take  (cls_take),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: bench/ook_pulse_width_receiver_checker.sv
// Checker for the OOK pulse width receiver: predicts each status word and compares it.
module ook_pulse_width_receiver_checker
   import ookr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  logic    full,
   input  req_type req_data,
   input  logic    empty,
   input  logic    pop,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      outstanding
);

   localparam int unsigned UNIT_US_P0 = 475;
   localparam int unsigned UNIT_US_P1 = 180;

   logic                   synced;
   logic                   held_prot;
   logic [MSG_WIDTH-1:0]   shift_bits;
   logic [COUNT_WIDTH-1:0] bits_seen;
   logic                   msg_held;
   rsp_type                status_q[$];

   function automatic longint unsigned pulse_us(input logic prot, input int unsigned units);
      return longint'(prot ? UNIT_US_P1 : UNIT_US_P0) * units;
   endfunction

   function automatic logic fits(input logic [TIME_WIDTH-1:0] width,
                                 input longint unsigned nominal);
      return (width >= nominal * 100 / 133) && (width <= nominal * 133 / 100);
   endfunction

   function automatic logic sync_fits(input logic [TIME_WIDTH-1:0] width, input logic prot);
      return fits(width, pulse_us(prot, prot ? 31 : 9000 / UNIT_US_P0));
   endfunction

   function automatic logic one_low_fits(input logic [TIME_WIDTH-1:0] width, input logic prot);
      return fits(width, pulse_us(prot, prot ? 1 : 4000 / UNIT_US_P0));
   endfunction

   function automatic logic zero_low_fits(input logic [TIME_WIDTH-1:0] width, input logic prot);
      return fits(width, pulse_us(prot, prot ? 3 : 2000 / UNIT_US_P0));
   endfunction

   function automatic logic high_fits(input logic [TIME_WIDTH-1:0] width, input logic prot);
      return fits(width, pulse_us(prot, prot ? 3 : 1)) || fits(width, pulse_us(prot, 1));
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] frame_bits(input logic prot);
      return prot ? COUNT_WIDTH'(24) : COUNT_WIDTH'(32);
   endfunction

   function automatic rsp_type held_status();
      rsp_type status;
      status = '0;
      if (msg_held) begin
         status.ready_res = 1'b1;
         status.protocol = held_prot;
         status.bit_length = frame_bits(held_prot);
         status.message = shift_bits;
      end
      return status;
   endfunction

   task automatic bump_count();
      if (bits_seen < COUNT_WIDTH'(MSG_WIDTH)) begin
         bits_seen++;
      end
   endtask

   task automatic advance_receiver(input req_type item);
      logic finish;
      logic prot;
      finish = 1'b0;
      prot = held_prot;
      if (item.op == OP_CLEAR) begin
         msg_held = 1'b0;
         shift_bits = '0;
         held_prot = 1'b0;
         synced = 1'b0;
      end else if (!msg_held) begin
         if (item.level) begin
            if (!synced) begin
               // protocol 1 is tested last so it wins on overlap
               if (sync_fits(item.interval_us, 1'b0)) begin
                  synced = 1'b1;
                  held_prot = 1'b0;
                  shift_bits = '0;
                  bits_seen = '0;
               end
               if (sync_fits(item.interval_us, 1'b1)) begin
                  synced = 1'b1;
                  held_prot = 1'b1;
                  shift_bits = '0;
                  bits_seen = '0;
               end
            end else if (one_low_fits(item.interval_us, prot)) begin
               bump_count();
               shift_bits = {shift_bits[MSG_WIDTH-2:0], 1'b1};
            end else if (zero_low_fits(item.interval_us, prot)) begin
               bump_count();
               shift_bits = {shift_bits[MSG_WIDTH-2:0], 1'b0};
            end else begin
               finish = 1'b1;
            end
         end else if (synced) begin
            if (!high_fits(item.interval_us, prot)) begin
               finish = 1'b1;
            end
            if (bits_seen >= frame_bits(prot)) begin
               finish = 1'b1;
            end
         end
         if (finish) begin
            if (bits_seen >= frame_bits(held_prot)) begin
               msg_held = 1'b1;
            end
            synced = 1'b0;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (fail_count < 50) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         synced = 1'b0;
         held_prot = 1'b0;
         shift_bits = '0;
         bits_seen = '0;
         msg_held = 1'b0;
         status_q.delete();
         fail_count = 0;
      end else begin
         if (pop && !empty) begin
            if (status_q.size() == 0) begin
               report_mismatch("unrequested transfer", '0, rsp_data.message);
            end else begin
               want = status_q.pop_front();
               if (rsp_data.ready_res !== want.ready_res) begin
                  report_mismatch("ready_res", want.ready_res, rsp_data.ready_res);
               end
               if (rsp_data.protocol !== want.protocol) begin
                  report_mismatch("protocol", want.protocol, rsp_data.protocol);
               end
               if (rsp_data.bit_length !== want.bit_length) begin
                  report_mismatch("bit_length", want.bit_length, rsp_data.bit_length);
               end
               if (rsp_data.message !== want.message) begin
                  report_mismatch("message", want.message, rsp_data.message);
               end
            end
         end
         if (push && !full) begin
            advance_receiver(req_data);
            status_q.push_back(held_status());
         end
      end
      outstanding = status_q.size();
   end

endmodule

// File: bench/ook_pulse_width_receiver_tb.sv
// Testbench top for the OOK pulse width receiver: clock, reset, stimulus and verdict.
module ook_pulse_width_receiver_tb;
   import ookr_pkg::*;

   localparam int ITEM_TARGET = 1400;
   localparam int CYCLE_LIMIT = 300000;
   localparam int LONG_HOLD_CYCLES = 80;

   typedef enum {SYNC_LOW, ONE_LOW, ZERO_LOW, ONE_HIGH, ZERO_HIGH} pulse_kind_type;

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   logic    empty;
   logic    pop;
   req_type req_data;
   rsp_type rsp_data;
   int      fail_count;
   int      outstanding;
   int      items_sent = 0;
   int      hold_requests = 0;
   int      cycle_count;
   bit      steady = 1'b0;

   ook_pulse_width_receiver dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   ook_pulse_width_receiver_checker status_check (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned nominal_us(input logic prot, input pulse_kind_type kind);
      case (kind)
         SYNC_LOW:  return prot ? 180 * 31 : 475 * (9000 / 475);
         ONE_LOW:   return prot ? 180 : 475 * (4000 / 475);
         ZERO_LOW:  return prot ? 540 : 475 * (2000 / 475);
         ONE_HIGH:  return prot ? 540 : 475;
         default:   return prot ? 180 : 475;
      endcase
   endfunction

   function automatic logic [23:0] width_near(input int unsigned nominal);
      int unsigned lo = nominal * 100 / 133;
      int unsigned hi = nominal * 133 / 100;
      case ($urandom_range(0, 9))
         0:       return 24'(lo);
         1:       return 24'(hi);
         default: return 24'($urandom_range(hi, lo));
      endcase
   endfunction

   function automatic logic [23:0] width_off(input int unsigned nominal);
      int unsigned lo = nominal * 100 / 133;
      int unsigned hi = nominal * 133 / 100;
      return $urandom_range(0, 1) ? 24'(lo - 1) : 24'(hi + 1);
   endfunction

   function automatic logic [23:0] random_width();
      pulse_kind_type kind;
      logic           prot;
      int             pick;
      kind = pulse_kind_type'($urandom_range(0, 4));
      prot = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 3);
      if (pick < 2) begin
         return 24'($urandom);
      end else if (pick == 2) begin
         return width_near(nominal_us(prot, kind));
      end
      return width_off(nominal_us(prot, kind));
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      if (!steady && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 9);
         repeat (gap) begin
            @(negedge clock);
            push <= 1'b0;
            req_data.op <= 1'($urandom);
            req_data.level <= 1'($urandom);
            req_data.interval_us <= 24'($urandom);
         end
      end
      @(negedge clock);
      push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_edge(input logic level, input logic [23:0] width);
      req_type item;
      item.op = OP_EDGE;
      item.level = level;
      item.interval_us = width;
      send_item(item);
   endtask

   task automatic send_clear();
      req_type item;
      item.op = OP_CLEAR;
      item.level = 1'($urandom);
      item.interval_us = 24'($urandom);
      send_item(item);
   endtask

   // sync rise, then per bit a fall and a rise, then the closing fall
   task automatic send_message(input logic prot, input int nbits, input int spoil_at);
      int          total;
      logic        bit_val;
      logic        level;
      int unsigned nominal;
      logic [23:0] width;
      total = 2 * nbits + 2;
      bit_val = 1'b0;
      for (int k = 0; k < total; k++) begin
         if (k == 0) begin
            level = 1'b1;
            nominal = nominal_us(prot, SYNC_LOW);
         end else if (k % 2 == 1) begin
            level = 1'b0;
            bit_val = 1'($urandom_range(0, 1));
            nominal = nominal_us(prot, bit_val ? ONE_HIGH : ZERO_HIGH);
         end else begin
            level = 1'b1;
            nominal = nominal_us(prot, bit_val ? ONE_LOW : ZERO_LOW);
         end
         width = width_near(nominal);
         if (k == spoil_at) begin
            case ($urandom_range(0, 2))
               0:       width = width_off(nominal);
               1:       width = 24'($urandom);
               default: level = !level;
            endcase
         end
         send_edge(level, width);
      end
   endtask

   // back-to-back rises run the bit count into saturation
   task automatic send_overrun(input logic prot);
      int count;
      count = $urandom_range(33, 40);
      send_edge(1'b1, width_near(nominal_us(prot, SYNC_LOW)));
      repeat (count) begin
         send_edge(1'b1, width_near(nominal_us(prot, $urandom_range(0, 1) ? ONE_LOW : ZERO_LOW)));
      end
      send_edge(1'b0, width_near(nominal_us(prot, ONE_HIGH)));
   endtask

   task automatic send_noise(input int count);
      repeat (count) begin
         if ($urandom_range(0, 5) == 0) begin
            send_clear();
         end else begin
            send_edge(1'($urandom_range(0, 1)), random_width());
         end
      end
   endtask

   initial begin : rsp_side
      int stall;
      int served;
      stall = 0;
      served = 0;
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            pop <= 1'b0;
         end else if (served != hold_requests) begin
            served++;
            stall = LONG_HOLD_CYCLES - 1;
            pop <= 1'b0;
         end else if (!steady && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(0, 8);
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int   choice;
      int   len;
      logic prot;
      bit   held_once;
      bit   drained_once;
      held_once = 1'b0;
      drained_once = 1'b0;
      reset = 1'b1;
      push = 1'b0;
      req_data = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      send_clear();
      send_edge(1'b0, 24'd0);
      send_edge(1'b1, 24'd0);
      send_edge(1'b1, 24'hFFFFFF);
      send_edge(1'b1, 24'd11372);
      send_edge(1'b1, 24'd7000);
      send_edge(1'b0, 24'd180);
      send_edge(1'b1, 24'd180);
      send_edge(1'b0, 24'd540);
      send_edge(1'b1, 24'd540);
      send_edge(1'b0, 24'd0);
      send_edge(1'b1, 24'd11371);
      send_edge(1'b0, 24'd475);
      send_edge(1'b1, 24'd3800);
      send_edge(1'b0, 24'd357);
      send_edge(1'b1, 24'd1900);
      send_edge(1'b1, 24'hFFFFFF);
      send_edge(1'b1, 24'd6428);
      send_edge(1'b1, 24'd135);
      send_clear();
      send_edge(1'b1, 24'd4195);
      send_edge(1'b1, 24'd7421);
      send_edge(1'b0, 24'd719);
      send_clear();

      while (items_sent < ITEM_TARGET) begin
         if (!held_once && items_sent >= 400) begin
            held_once = 1'b1;
            hold_requests++;
         end
         if (!drained_once && items_sent >= 800) begin
            drained_once = 1'b1;
            @(negedge clock);
            push <= 1'b0;
            while (outstanding != 0) @(negedge clock);
         end
         if (items_sent >= 1150) begin
            steady = 1'b1;
         end
         choice = $urandom_range(0, 99);
         prot = 1'($urandom_range(0, 1));
         len = prot ? 24 : 32;
         if (choice < 55) begin
            send_message(prot, len,
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 * len + 1) : -1);
         end else if (choice < 65) begin
            send_overrun(prot);
         end else if (choice < 75) begin
            send_message(prot, $urandom_range(1, 40), -1);
         end else if (choice < 90) begin
            send_noise($urandom_range(1, 8));
         end else begin
            send_clear();
         end
         choice = $urandom_range(0, 9);
         if (choice >= 2 && choice < 5) begin
            send_noise($urandom_range(1, 3));
            send_clear();
         end else if (choice >= 5) begin
            send_clear();
         end
      end

      @(negedge clock);
      push <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("ook_pulse_width_receiver_tb: PASS");
      end else begin
         $display("ook_pulse_width_receiver_tb: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ook_pulse_width_receiver_tb: FAIL");
      $finish;
   end

endmodule
